>>> sv/dltq_pkg.sv
// Package for the delta-list task timer queue.
// Holds the field codes, datapath commands and status struct shared by the controller, datapath, top level and bench.
// Depends on nothing.
package dltq_pkg;

  // slot pointers are five bits wide; all ones marks the end of a list
  localparam int              IDX_W          = 5;
  localparam logic [IDX_W-1:0] NO_SLOT       = 5'd31;
  localparam int              TASK_SLOTS_DEF = 16;
  localparam logic [15:0]     TICK_LEN_RST   = 16'd10;
  // at most this many results per dispatch item
  localparam int              MAX_OUT        = 16;
  localparam int              CNT_W          = 5;

  // input function codes
  localparam logic [1:0] FN_TICK = 2'd0;
  localparam logic [1:0] FN_ADD  = 2'd1;
  localparam logic [1:0] FN_DEL  = 2'd2;
  localparam logic [1:0] FN_DISP = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;
  localparam logic [1:0] ST_NONE = 2'd3;

  // datapath commands, one per cycle
  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_DIV_GO,
    DP_INS_TAKE,
    DP_INS_WALK,
    DP_INS_L1,
    DP_INS_L2,
    DP_INS_L3,
    DP_DEL_WALK,
    DP_DEL_UNLINK,
    DP_DEL_FIX,
    DP_FREE,
    DP_TICK_DEC,
    DP_TICK_POP,
    DP_DISP_SCAN,
    DP_RES_TICK,
    DP_RES_ADD,
    DP_RES_DEL,
    DP_RES_DISP,
    DP_RES_NONE
  } dp_cmd_t;

  // datapath status seen by the controller
  typedef struct packed {
    logic div_busy;
    logic free_ok;
    logic walk_done;
    logic del_bad;
    logic del_end;
    logic del_hit;
    logic pop_ok;
    logic per_nz;
    logic scan_end;
    logic scan_ready;
    logic disp_last;
    logic out_busy;
  } dp_stat_t;

endpackage

>>> sv/dltq_div.sv
// Restoring divider, one quotient bit per cycle.
// Used by the datapath to turn time units into ticks; depends on no other file.
module dltq_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        busy,
  output logic [31:0] quotient
);

  logic [31:0] q_r;
  logic [15:0] rem_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic [16:0] shifted;
  logic        ge;

  // one shift-and-subtract step
  assign shifted = {rem_r, q_r[31]};
  assign ge      = shifted >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 6'd32;
      q_r    <= dividend;
      rem_r  <= 16'd0;
    end else if (busy_r) begin
      q_r   <= {q_r[30:0], ge};
      rem_r <= ge ? 16'(shifted - {1'b0, divisor}) : shifted[15:0];
      cnt_r <= cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy     = busy_r;
  assign quotient = q_r;

endmodule

>>> sv/dltq_dp.sv
// Datapath of the timer queue: slot stores, list pointers, divider, result register.
// Driven by dltq_ctrl through dltq_pkg::dp_cmd_t; uses dltq_div.
module dltq_dp #(
  parameter int TASK_SLOTS = dltq_pkg::TASK_SLOTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dltq_pkg::dp_cmd_t    cmd,
  output dltq_pkg::dp_stat_t   stat,
  input  logic                 cfg_wr_en,
  input  logic [15:0]          cfg_wr_data,
  input  logic [15:0]          in_task_tag,
  input  logic [31:0]          in_first_delay,
  input  logic [31:0]          in_repeat_period,
  input  logic [7:0]           in_slot_to_delete,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_status,
  output logic [5:0]           out_slot,
  output logic [15:0]          out_run_tag,
  output logic                 out_last
);

  localparam int IW = dltq_pkg::IDX_W;
  localparam int SW = $clog2(TASK_SLOTS);
  localparam logic [IW-1:0] NSLOT = IW'(TASK_SLOTS);

  // slot stores
  logic [15:0]         tag_r  [TASK_SLOTS];
  logic [31:0]         dly_r  [TASK_SLOTS];
  logic [31:0]         pst_r  [TASK_SLOTS];
  logic [IW-1:0]       link_r [TASK_SLOTS];
  logic [TASK_SLOTS-1:0] rdy_r;
  logic [TASK_SLOTS-1:0] occ_r;

  // pointers and working registers
  logic [IW-1:0] head_r, free_r, cur_r, prev_r, new_r, nx_r, victim_r, idx_r;
  logic [31:0]   cum_r, ticks_r, newd_r, dsave_r, dividend_r, per_r;
  logic [15:0]   tag_hold_r, tick_len_r;
  logic          clamp_r, fail_r, bad_r;
  logic [dltq_pkg::CNT_W-1:0] outcnt_r;

  logic          out_valid_r, out_last_r;
  logic [1:0]    out_status_r;
  logic [5:0]    out_slot_r;
  logic [15:0]   out_run_tag_r;

  logic [IW-1:0] rd_addr;
  logic [SW-1:0] ra;
  logic [IW-1:0] rd_link;
  logic [31:0]   rd_dly, rd_per;
  logic [15:0]   rd_tag;
  logic [32:0]   walk_sum;
  logic [31:0]   quot, ticks_new;
  logic [15:0]   divisor;
  logic          div_busy, above_rdy, pop_ok, disp_last, in_range;

  function automatic logic slot_ok(input logic [IW-1:0] x);
    return x < NSLOT;
  endfunction

  // tick length of zero counts as one
  assign divisor = (tick_len_r == 16'd0) ? 16'd1 : tick_len_r;

  dltq_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd == dltq_pkg::DP_DIV_GO),
    .dividend (dividend_r),
    .divisor  (divisor),
    .busy     (div_busy),
    .quotient (quot)
  );

  assign ticks_new = (clamp_r && quot == 32'd0) ? 32'd1 : quot;

  // single read port into the slot stores
  always_comb begin
    unique case (cmd)
      dltq_pkg::DP_INS_TAKE: rd_addr = free_r;
      dltq_pkg::DP_TICK_DEC,
      dltq_pkg::DP_TICK_POP: rd_addr = head_r;
      dltq_pkg::DP_DEL_FIX:  rd_addr = nx_r;
      dltq_pkg::DP_RES_DISP: rd_addr = idx_r;
      default:               rd_addr = cur_r;
    endcase
  end

  assign ra      = rd_addr[SW-1:0];
  assign rd_link = link_r[ra];
  assign rd_dly  = dly_r[ra];
  assign rd_per  = pst_r[ra];
  assign rd_tag  = tag_r[ra];

  assign walk_sum = {1'b0, cum_r} + {1'b0, rd_dly};
  assign pop_ok   = slot_ok(head_r) && (rd_dly == 32'd0);
  assign in_range = in_slot_to_delete < 8'(TASK_SLOTS);

  // any ready slot above the scan index
  always_comb begin
    above_rdy = 1'b0;
    for (int j = 0; j < TASK_SLOTS; j++) begin
      if (rdy_r[j] && (IW'(j) > idx_r)) begin
        above_rdy = 1'b1;
      end
    end
  end

  assign disp_last = !above_rdy ||
                     (outcnt_r == dltq_pkg::CNT_W'(dltq_pkg::MAX_OUT - 1));

  // status to the controller
  always_comb begin
    stat.div_busy   = div_busy;
    stat.free_ok    = slot_ok(free_r);
    stat.walk_done  = !slot_ok(cur_r) || ({1'b0, ticks_r} < walk_sum);
    stat.del_bad    = bad_r;
    stat.del_end    = !slot_ok(cur_r);
    stat.del_hit    = slot_ok(cur_r) && (cur_r == victim_r);
    stat.pop_ok     = pop_ok;
    stat.per_nz     = rd_per != 32'd0;
    stat.scan_end   = idx_r == NSLOT;
    stat.scan_ready = slot_ok(idx_r) && rdy_r[idx_r[SW-1:0]];
    stat.disp_last  = disp_last;
    stat.out_busy   = out_valid_r;
  end

  // stores, pointers and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        tag_r[i]  <= 16'd0;
        dly_r[i]  <= 32'd0;
        pst_r[i]  <= 32'd0;
        link_r[i] <= (i == 0) ? dltq_pkg::NO_SLOT : IW'(i - 1);
      end
      rdy_r       <= '0;
      occ_r       <= '0;
      head_r      <= dltq_pkg::NO_SLOT;
      free_r      <= NSLOT - IW'(1);
      tick_len_r  <= dltq_pkg::TICK_LEN_RST;
      out_valid_r <= 1'b0;
      fail_r      <= 1'b0;
      bad_r       <= 1'b0;
      idx_r       <= '0;
      outcnt_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        tick_len_r <= cfg_wr_data;
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (cmd)
        dltq_pkg::DP_LOAD: begin
          tag_hold_r <= in_task_tag;
          per_r      <= in_repeat_period;
          dividend_r <= in_first_delay;
          clamp_r    <= 1'b0;
          fail_r     <= 1'b0;
          victim_r   <= in_slot_to_delete[IW-1:0];
          bad_r      <= !in_range || !occ_r[in_slot_to_delete[SW-1:0]];
          cur_r      <= head_r;
          prev_r     <= dltq_pkg::NO_SLOT;
          idx_r      <= '0;
          outcnt_r   <= '0;
        end
        // take a slot off the free list and fill it
        dltq_pkg::DP_INS_TAKE: begin
          if (slot_ok(free_r)) begin
            new_r                <= free_r;
            free_r               <= rd_link;
            tag_r[free_r[SW-1:0]] <= tag_hold_r;
            pst_r[free_r[SW-1:0]] <= per_r;
            rdy_r[free_r[SW-1:0]] <= 1'b0;
            occ_r[free_r[SW-1:0]] <= 1'b1;
            ticks_r              <= ticks_new;
            cur_r                <= head_r;
            prev_r               <= dltq_pkg::NO_SLOT;
            cum_r                <= 32'd0;
          end else begin
            fail_r <= 1'b1;
          end
        end
        // walk past entries due no later than the new one
        dltq_pkg::DP_INS_WALK: begin
          if (!stat.walk_done) begin
            cum_r  <= walk_sum[31:0];
            prev_r <= cur_r;
            cur_r  <= rd_link;
          end
        end
        dltq_pkg::DP_INS_L1: begin
          dly_r[new_r[SW-1:0]]  <= ticks_r - cum_r;
          link_r[new_r[SW-1:0]] <= cur_r;
          newd_r                <= ticks_r - cum_r;
        end
        dltq_pkg::DP_INS_L2: begin
          if (slot_ok(prev_r)) begin
            link_r[prev_r[SW-1:0]] <= new_r;
          end else begin
            head_r <= new_r;
          end
        end
        dltq_pkg::DP_INS_L3: begin
          if (slot_ok(cur_r)) begin
            dly_r[cur_r[SW-1:0]] <= rd_dly - newd_r;
          end
        end
        dltq_pkg::DP_DEL_WALK: begin
          if (slot_ok(cur_r) && cur_r != victim_r) begin
            prev_r <= cur_r;
            cur_r  <= rd_link;
          end
        end
        dltq_pkg::DP_DEL_UNLINK: begin
          nx_r    <= rd_link;
          dsave_r <= rd_dly;
          if (slot_ok(prev_r)) begin
            link_r[prev_r[SW-1:0]] <= rd_link;
          end else begin
            head_r <= rd_link;
          end
        end
        // successor inherits the removed delay
        dltq_pkg::DP_DEL_FIX: begin
          if (slot_ok(nx_r)) begin
            dly_r[nx_r[SW-1:0]] <= rd_dly + dsave_r;
          end
        end
        dltq_pkg::DP_FREE: begin
          tag_r[victim_r[SW-1:0]]  <= 16'd0;
          dly_r[victim_r[SW-1:0]]  <= 32'd0;
          pst_r[victim_r[SW-1:0]]  <= 32'd0;
          rdy_r[victim_r[SW-1:0]]  <= 1'b0;
          occ_r[victim_r[SW-1:0]]  <= 1'b0;
          link_r[victim_r[SW-1:0]] <= free_r;
          free_r                   <= victim_r;
          idx_r                    <= idx_r + IW'(1);
        end
        dltq_pkg::DP_TICK_DEC: begin
          if (slot_ok(head_r) && rd_dly != 32'd0) begin
            dly_r[head_r[SW-1:0]] <= rd_dly - 32'd1;
          end
        end
        // pop one due entry off the head
        dltq_pkg::DP_TICK_POP: begin
          if (pop_ok) begin
            rdy_r[head_r[SW-1:0]]  <= 1'b1;
            link_r[head_r[SW-1:0]] <= dltq_pkg::NO_SLOT;
            head_r                 <= rd_link;
            tag_hold_r             <= rd_tag;
            per_r                  <= rd_per;
            dividend_r             <= rd_per;
            clamp_r                <= 1'b1;
          end
        end
        dltq_pkg::DP_DISP_SCAN: begin
          if (!stat.scan_end && !stat.scan_ready) begin
            idx_r <= idx_r + IW'(1);
          end
        end
        dltq_pkg::DP_RES_TICK: begin
          out_valid_r   <= 1'b1;
          out_status_r  <= fail_r ? dltq_pkg::ST_FULL : dltq_pkg::ST_OK;
          out_slot_r    <= 6'd0;
          out_run_tag_r <= 16'd0;
          out_last_r    <= 1'b1;
        end
        dltq_pkg::DP_RES_ADD: begin
          out_valid_r   <= 1'b1;
          out_status_r  <= fail_r ? dltq_pkg::ST_FULL : dltq_pkg::ST_OK;
          out_slot_r    <= fail_r ? 6'd0 : {1'b0, new_r};
          out_run_tag_r <= 16'd0;
          out_last_r    <= 1'b1;
        end
        dltq_pkg::DP_RES_DEL: begin
          out_valid_r   <= 1'b1;
          out_status_r  <= bad_r ? dltq_pkg::ST_BAD : dltq_pkg::ST_OK;
          out_slot_r    <= bad_r ? 6'd0 : {1'b0, victim_r};
          out_run_tag_r <= 16'd0;
          out_last_r    <= 1'b1;
        end
        dltq_pkg::DP_RES_DISP: begin
          out_valid_r   <= 1'b1;
          out_status_r  <= dltq_pkg::ST_OK;
          out_slot_r    <= {1'b0, idx_r};
          out_run_tag_r <= rd_tag;
          out_last_r    <= disp_last;
          victim_r      <= idx_r;
          outcnt_r      <= outcnt_r + dltq_pkg::CNT_W'(1);
        end
        dltq_pkg::DP_RES_NONE: begin
          out_valid_r   <= 1'b1;
          out_status_r  <= dltq_pkg::ST_NONE;
          out_slot_r    <= 6'd0;
          out_run_tag_r <= 16'd0;
          out_last_r    <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_slot    = out_slot_r;
  assign out_run_tag = out_run_tag_r;
  assign out_last    = out_last_r;

endmodule

>>> sv/dltq_ctrl.sv
// Controller of the timer queue: sequences list walks, division and results.
// Issues dltq_pkg::dp_cmd_t to dltq_dp and reads back dltq_pkg::dp_stat_t.
module dltq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [1:0]         in_func,
  output logic               in_ready,
  input  dltq_pkg::dp_stat_t stat,
  output dltq_pkg::dp_cmd_t  cmd
);

  typedef enum logic [20:0] {
    S_IDLE  = 21'h000001,
    S_DIVGO = 21'h000002,
    S_DIVW  = 21'h000004,
    S_ITAKE = 21'h000008,
    S_IWALK = 21'h000010,
    S_IL1   = 21'h000020,
    S_IL2   = 21'h000040,
    S_IL3   = 21'h000080,
    S_RADD  = 21'h000100,
    S_TDEC  = 21'h000200,
    S_TPOP  = 21'h000400,
    S_RTICK = 21'h000800,
    S_DCHK  = 21'h001000,
    S_DWALK = 21'h002000,
    S_DUNL  = 21'h004000,
    S_DFIX  = 21'h008000,
    S_FREE  = 21'h010000,
    S_RDEL  = 21'h020000,
    S_SCAN  = 21'h040000,
    S_RDISP = 21'h080000,
    S_RNONE = 21'h100000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] func_r;
  logic       disp_last_r;
  logic       is_add;

  assign is_add   = func_r == dltq_pkg::FN_ADD;
  assign in_ready = state_r == S_IDLE;

  // next state and command
  always_comb begin
    state_nxt = state_r;
    cmd       = dltq_pkg::DP_NOP;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd = dltq_pkg::DP_LOAD;
          unique case (in_func)
            dltq_pkg::FN_TICK: state_nxt = S_TDEC;
            dltq_pkg::FN_ADD:  state_nxt = S_DIVGO;
            dltq_pkg::FN_DEL:  state_nxt = S_DCHK;
            default:           state_nxt = S_SCAN;
          endcase
        end
      end
      S_DIVGO: begin
        cmd       = dltq_pkg::DP_DIV_GO;
        state_nxt = S_DIVW;
      end
      S_DIVW: begin
        if (!stat.div_busy) state_nxt = S_ITAKE;
      end
      S_ITAKE: begin
        cmd = dltq_pkg::DP_INS_TAKE;
        if (!stat.free_ok) state_nxt = is_add ? S_RADD : S_TPOP;
        else               state_nxt = S_IWALK;
      end
      S_IWALK: begin
        cmd = dltq_pkg::DP_INS_WALK;
        if (stat.walk_done) state_nxt = S_IL1;
      end
      S_IL1: begin
        cmd       = dltq_pkg::DP_INS_L1;
        state_nxt = S_IL2;
      end
      S_IL2: begin
        cmd       = dltq_pkg::DP_INS_L2;
        state_nxt = S_IL3;
      end
      S_IL3: begin
        cmd       = dltq_pkg::DP_INS_L3;
        state_nxt = is_add ? S_RADD : S_TPOP;
      end
      S_RADD: begin
        if (!stat.out_busy) begin
          cmd       = dltq_pkg::DP_RES_ADD;
          state_nxt = S_IDLE;
        end
      end
      S_TDEC: begin
        cmd       = dltq_pkg::DP_TICK_DEC;
        state_nxt = S_TPOP;
      end
      S_TPOP: begin
        cmd = dltq_pkg::DP_TICK_POP;
        priority if (stat.pop_ok && stat.per_nz) state_nxt = S_DIVGO;
        else if (stat.pop_ok)                    state_nxt = S_TPOP;
        else                                     state_nxt = S_RTICK;
      end
      S_RTICK: begin
        if (!stat.out_busy) begin
          cmd       = dltq_pkg::DP_RES_TICK;
          state_nxt = S_IDLE;
        end
      end
      S_DCHK: begin
        state_nxt = stat.del_bad ? S_RDEL : S_DWALK;
      end
      S_DWALK: begin
        cmd = dltq_pkg::DP_DEL_WALK;
        priority if (stat.del_end) state_nxt = S_FREE;
        else if (stat.del_hit)     state_nxt = S_DUNL;
      end
      S_DUNL: begin
        cmd       = dltq_pkg::DP_DEL_UNLINK;
        state_nxt = S_DFIX;
      end
      S_DFIX: begin
        cmd       = dltq_pkg::DP_DEL_FIX;
        state_nxt = S_FREE;
      end
      S_FREE: begin
        cmd = dltq_pkg::DP_FREE;
        if (func_r == dltq_pkg::FN_DISP) state_nxt = disp_last_r ? S_IDLE : S_SCAN;
        else                             state_nxt = S_RDEL;
      end
      S_RDEL: begin
        if (!stat.out_busy) begin
          cmd       = dltq_pkg::DP_RES_DEL;
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd = dltq_pkg::DP_DISP_SCAN;
        priority if (stat.scan_end) state_nxt = S_RNONE;
        else if (stat.scan_ready)   state_nxt = S_RDISP;
      end
      S_RDISP: begin
        if (!stat.out_busy) begin
          cmd       = dltq_pkg::DP_RES_DISP;
          state_nxt = S_FREE;
        end
      end
      S_RNONE: begin
        if (!stat.out_busy) begin
          cmd       = dltq_pkg::DP_RES_NONE;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state, function and end-of-dispatch flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      func_r      <= dltq_pkg::FN_TICK;
      disp_last_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_IDLE && in_valid) begin
        func_r      <= in_func;
        disp_last_r <= 1'b0;
      end
      if (state_r == S_RDISP && !stat.out_busy) begin
        disp_last_r <= stat.disp_last;
      end
    end
  end

endmodule

>>> sv/delta_list_task_timer_queue_unit.sv
// Top level of the delta-list task timer queue.
// Joins dltq_ctrl and dltq_dp; uses dltq_pkg.
//
// Usage: one item on the in_ channel carries a function code and its operands
// (tick, add task, delete slot, dispatch ready tasks). Each item gives one
// result on the out_ channel, or for dispatch one result per dispatched slot
// (up to 16), or one none result when no slot is ready; out_last marks the
// final result of an item. in_ready is high only while the sequencer is
// idle, so items are taken one at a time. A bad delete goes straight to its
// result; a delete walks the waiting list to the slot, or the whole list
// when the slot is not waiting. Add divides the delay into ticks with the
// 32-step tick divider, then walks past each entry due no later, and skips
// the walk when the pool is full. A tick decrements the head entry and pops
// each due entry; each periodic re-add divides and walks the same way.
// Dispatch scans the slots and emits each ready one. The divider and the
// single-port walk of the slot pool set how long an item runs.
// A result waits in the output register while out_ready is low; the next item
// is still accepted and runs until it needs that register.
// Reset (synchronous, rst_n low) empties the waiting list, chains all slots
// into the free list from the top slot down and sets the tick length to 10.
// cfg_wr_en writes the tick length; write it only while the block is idle.
module delta_list_task_timer_queue_unit #(
  parameter int TASK_SLOTS = dltq_pkg::TASK_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [15:0] in_task_tag,
  input  logic [31:0] in_first_delay,
  input  logic [31:0] in_repeat_period,
  input  logic [7:0]  in_slot_to_delete,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [5:0]  out_slot,
  output logic [15:0] out_run_tag,
  output logic        out_last
);

  dltq_pkg::dp_cmd_t  cmd;
  dltq_pkg::dp_stat_t stat;

  dltq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dltq_dp #(.TASK_SLOTS(TASK_SLOTS)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_task_tag       (in_task_tag),
    .in_first_delay    (in_first_delay),
    .in_repeat_period  (in_repeat_period),
    .in_slot_to_delete (in_slot_to_delete),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_slot          (out_slot),
    .out_run_tag       (out_run_tag),
    .out_last          (out_last)
  );

`ifndef SYNTH
  // a result is only written into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == dltq_pkg::DP_RES_TICK || cmd == dltq_pkg::DP_RES_ADD ||
     cmd == dltq_pkg::DP_RES_DEL || cmd == dltq_pkg::DP_RES_DISP ||
     cmd == dltq_pkg::DP_RES_NONE) |-> !stat.out_busy)
    else $error("result written over a pending result");

  // the divider is never restarted while running
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == dltq_pkg::DP_DIV_GO) |-> !stat.div_busy)
    else $error("divider started while busy");

  // an accepted item closes the input until it is done
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted twice in a row");
`endif

endmodule

>>> bench/tb_top.sv
// Self-checking bench for delta_list_task_timer_queue_unit.
// Carries its own model of the slot pool and timer lists; depends on dltq_pkg and the unit.
module tb_top;

  localparam int NSLOT = 16;
  localparam logic [4:0] NIL = 5'd31;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  slot;
    logic [15:0] run_tag;
    logic        last;
  } timer_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_func = dltq_pkg::FN_TICK;
  logic [15:0] in_task_tag = '0;
  logic [31:0] in_first_delay = '0;
  logic [31:0] in_repeat_period = '0;
  logic [7:0] in_slot_to_delete = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic [5:0] out_slot;
  logic [15:0] out_run_tag;
  logic out_last;

  // pool mirror
  logic [15:0] m_tag [NSLOT];
  logic [31:0] m_dly [NSLOT];
  logic [31:0] m_per [NSLOT];
  logic [4:0]  m_lnk [NSLOT];
  logic        m_rdy [NSLOT];
  logic        m_occ [NSLOT];
  logic [4:0]  m_wait_head, m_free_head;
  logic [15:0] m_tick_len;

  timer_res_t due_results[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  delta_list_task_timer_queue_unit u_dut (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_func(in_func),
    .in_task_tag(in_task_tag), .in_first_delay(in_first_delay),
    .in_repeat_period(in_repeat_period), .in_slot_to_delete(in_slot_to_delete),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_slot(out_slot), .out_run_tag(out_run_tag), .out_last(out_last)
  );

  function automatic logic [31:0] units_to_ticks(logic [31:0] t);
    logic [31:0] d;
    d = (m_tick_len == 0) ? 32'd1 : {16'd0, m_tick_len};
    return t / d;
  endfunction

  function automatic void mirror_reset();
    for (int i = 0; i < NSLOT; i++) begin
      m_tag[i] = '0; m_dly[i] = '0; m_per[i] = '0; m_rdy[i] = 0; m_occ[i] = 0;
      m_lnk[i] = (i == 0) ? NIL : 5'(i - 1);
    end
    m_free_head = 5'(NSLOT - 1);
    m_wait_head = NIL;
    m_tick_len = dltq_pkg::TICK_LEN_RST;
  endfunction

  function automatic void release_slot(int i);
    m_tag[i] = '0; m_dly[i] = '0; m_per[i] = '0; m_rdy[i] = 0; m_occ[i] = 0;
    m_lnk[i] = m_free_head;
    m_free_head = 5'(i);
  endfunction

  // returns NIL when the pool is full
  function automatic logic [4:0] schedule_task(logic [15:0] tag, logic [31:0] ticks,
                                               logic [31:0] per);
    logic [4:0] n, cur, prev;
    logic [63:0] cum;
    n = m_free_head;
    prev = NIL;
    cum = 0;
    if (n >= NSLOT) return NIL;
    m_free_head = m_lnk[n];
    m_tag[n] = tag; m_per[n] = per; m_rdy[n] = 0; m_occ[n] = 1;
    cur = m_wait_head;
    for (int s = 0; s < NSLOT && cur < NSLOT; s++) begin
      if ({32'd0, ticks} < cum + {32'd0, m_dly[cur]}) break;
      cum += {32'd0, m_dly[cur]};
      prev = cur;
      cur = m_lnk[cur];
    end
    if (cur >= NSLOT) cur = NIL;
    if (prev == NIL) begin
      m_wait_head = n;
      m_dly[n] = ticks;
    end else begin
      m_lnk[prev] = n;
      m_dly[n] = ticks - cum[31:0];
    end
    m_lnk[n] = cur;
    if (cur < NSLOT) m_dly[cur] -= m_dly[n];
    return n;
  endfunction

  function automatic logic [1:0] remove_slot(int i);
    logic [4:0] cur, prev, nx;
    cur = m_wait_head;
    prev = NIL;
    if (i >= NSLOT) return dltq_pkg::ST_BAD;
    if (!m_occ[i]) return dltq_pkg::ST_BAD;
    for (int s = 0; s < NSLOT && cur < NSLOT; s++) begin
      if (cur == i) begin
        nx = m_lnk[cur];
        if (prev == NIL) m_wait_head = nx;
        else m_lnk[prev] = nx;
        if (nx < NSLOT) m_dly[nx] += m_dly[cur];
        break;
      end
      prev = cur;
      cur = m_lnk[cur];
    end
    release_slot(i);
    return dltq_pkg::ST_OK;
  endfunction

  function automatic logic [1:0] advance_tick();
    logic [1:0] st;
    logic [4:0] t;
    logic [31:0] tk;
    st = dltq_pkg::ST_OK;
    if (m_wait_head >= NSLOT) return dltq_pkg::ST_OK;
    if (m_dly[m_wait_head] > 0) m_dly[m_wait_head]--;
    for (int s = 0; s < NSLOT; s++) begin
      t = m_wait_head;
      if (t >= NSLOT) break;
      if (m_dly[t] != 0) break;
      m_rdy[t] = 1;
      m_wait_head = m_lnk[t];
      m_lnk[t] = NIL;
      if (m_per[t] > 0) begin
        tk = units_to_ticks(m_per[t]);
        if (tk == 0) tk = 1;
        if (schedule_task(m_tag[t], tk, m_per[t]) == NIL) st = dltq_pkg::ST_FULL;
      end
    end
    return st;
  endfunction

  // queue the results one item causes
  function automatic void predict_timer_results(logic [1:0] fn, logic [15:0] tag,
      logic [31:0] dly, logic [31:0] per, logic [7:0] dslot);
    timer_res_t r;
    logic [4:0] s;
    logic [1:0] st;
    int n;
    n = 0;
    r = '0;
    case (fn)
      dltq_pkg::FN_TICK: begin
        r.status = advance_tick();
        due_results.push_back(r);
      end
      dltq_pkg::FN_ADD: begin
        s = schedule_task(tag, units_to_ticks(dly), per);
        if (s == NIL) r.status = dltq_pkg::ST_FULL;
        else r.slot = {1'b0, s};
        due_results.push_back(r);
      end
      dltq_pkg::FN_DEL: begin
        st = remove_slot(int'(dslot));
        r.status = st;
        r.slot = (st == dltq_pkg::ST_OK) ? dslot[5:0] : 6'd0;
        due_results.push_back(r);
      end
      default: begin
        for (int i = 0; i < NSLOT && n < dltq_pkg::MAX_OUT; i++) begin
          if (m_rdy[i]) begin
            r = '0;
            r.slot = 6'(i);
            r.run_tag = m_tag[i];
            m_rdy[i] = 0;
            void'(remove_slot(i));
            due_results.push_back(r);
            n++;
          end
        end
        if (n == 0) begin
          r = '0;
          r.status = dltq_pkg::ST_NONE;
          due_results.push_back(r);
        end
      end
    endcase
    r = due_results.pop_back();
    r.last = 1'b1;
    due_results.push_back(r);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    timer_res_t e;
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        report_mismatch("unexpected item", 32'd0, 32'd0);
      end else begin
        e = due_results.pop_front();
        if (out_status !== e.status)
          report_mismatch("status", 32'(out_status), 32'(e.status));
        if (out_slot !== e.slot)
          report_mismatch("slot", 32'(out_slot), 32'(e.slot));
        if (out_run_tag !== e.run_tag)
          report_mismatch("run_tag", 32'(out_run_tag), 32'(e.run_tag));
        if (out_last !== e.last)
          report_mismatch("last", 32'(out_last), 32'(e.last));
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // valid drops only when the sender idles or the bench waits
  task automatic send_item(logic [1:0] fn, logic [15:0] tag, logic [31:0] dly,
                           logic [31:0] per, logic [7:0] dslot);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= fn;
    in_task_tag <= tag;
    in_first_delay <= dly;
    in_repeat_period <= per;
    in_slot_to_delete <= dslot;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_timer_results(fn, tag, dly, per, dslot);
  endtask

  // wait until idle; also lets a late periodic re-add finish
  task automatic drain_results();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (700) @(posedge clk);
  endtask

  task automatic write_tick_length(logic [15:0] v);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    m_tick_len = v;
  endtask

  task automatic test_directed();
    send_item(dltq_pkg::FN_DISP, 16'h0, 0, 0, 0);
    send_item(dltq_pkg::FN_TICK, 16'h0, 0, 0, 0);
    send_item(dltq_pkg::FN_DEL, 0, 0, 0, 8'hFF);
    send_item(dltq_pkg::FN_DEL, 0, 0, 0, 8'd16);
    send_item(dltq_pkg::FN_DEL, 0, 0, 0, 8'd3);
    send_item(dltq_pkg::FN_ADD, 16'hFFFF, 32'd0, 32'd0, 0);
    send_item(dltq_pkg::FN_ADD, 16'hA5A5, 32'd20, 32'd5, 8'hFF);
    send_item(dltq_pkg::FN_ADD, 16'h5A5A, 32'd20, 32'hFFFF_FFFF, 0);
    send_item(dltq_pkg::FN_ADD, 16'h1234, 32'hFFFF_FFFF, 32'd0, 0);
    send_item(dltq_pkg::FN_TICK, 0, 0, 0, 0);
    send_item(dltq_pkg::FN_DEL, 0, 0, 0, 8'd14);
    send_item(dltq_pkg::FN_TICK, 0, 0, 0, 0);
    send_item(dltq_pkg::FN_TICK, 0, 0, 0, 0);
    send_item(dltq_pkg::FN_DISP, 0, 0, 0, 0);
    drain_results();
    // fill the pool to hit the full cases, then dispatch many at once
    for (int i = 0; i < 17; i++) send_item(dltq_pkg::FN_ADD, 16'(i), 32'd0, 32'd1, 0);
    send_item(dltq_pkg::FN_TICK, 0, 0, 0, 0);
    send_item(dltq_pkg::FN_DISP, 0, 0, 0, 0);
    send_item(dltq_pkg::FN_DISP, 0, 0, 0, 0);
  endtask

  task automatic test_random(int count);
    logic [1:0] fn;
    logic [31:0] dly, per;
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      fn = (r < 40) ? dltq_pkg::FN_ADD : (r < 65) ? dltq_pkg::FN_TICK :
           (r < 82) ? dltq_pkg::FN_DISP : dltq_pkg::FN_DEL;
      dly = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(80));
      case ($urandom_range(5))
        0: per = $urandom;
        1, 2: per = 32'($urandom_range(60));
        default: per = 0;
      endcase
      send_item(fn, 16'($urandom), dly, per,
                ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(15)));
    end
  endtask

  task automatic test_cfg_sweep();
    write_tick_length(16'd0);
    test_random(40);
    write_tick_length(16'hFFFF);
    test_random(30);
    write_tick_length(16'd1);
    test_random(40);
    write_tick_length(16'd7);
  endtask

  initial begin
    mirror_reset();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 19; recv_idle_pct = 87;
    test_directed();
    test_random(50);
    // hold off until everything has come back
    drain_results();
    send_idle_pct = 87; recv_idle_pct = 19;
    test_random(50);
    test_cfg_sweep();
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(60);
    drain_results();
    if (errors == 0) $display("delta_list_task_timer_queue_unit verification clean");
    else $display("delta_list_task_timer_queue_unit verification failed");
    $finish;
  end

  // watchdog
  initial begin
    #60000000;
    $display("delta_list_task_timer_queue_unit verification failed");
    $finish;
  end

endmodule
